/* rtl/fpfa_pkg.sv */
// package: shared codes, field widths, state and handshake types for the fit allocator
`timescale 1ns / 1ps

package fpfa_pkg;

    // field widths fixed by the stream format
    localparam int KIND_W     = 1;
    localparam int PIDX_W     = 4;
    localparam int SIZE_IN_W  = 16;
    localparam int CHOSEN_W   = 4;
    localparam int REQNUM_W   = 8;
    localparam int POLICY_W   = 2;
    localparam int PCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

    // fit policy codes, the unused code acts as first fit
    localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'b1;

    // register reset values
    localparam logic [POLICY_W-1:0] POLICY_RESET = FIT_FIRST;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } fpfa_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // write one partition size
        logic start;   // open a new request scan
        logic issue;   // read the next table entry
        logic finish;  // commit the pick and load the result register
    } fpfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic more;         // entries still to be read
        logic cmp_pending;  // a read entry still waits for its compare
        logic out_free;     // result register can take a new result
    } fpfa_status_t;

endpackage

/* rtl/fpfa_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fpfa_ctrl.sv */
// controller: sequences load, table scan and result hand-off
`timescale 1ns / 1ps

module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [KIND_W-1:0]   kind,
    input  fpfa_status_t        status,
    output fpfa_cmd_t           cmd
);

    fpfa_state_t state_reg;
    fpfa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (kind == KIND_REQUEST)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = status.more;
                if (!status.more && !status.cmp_pending)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/fpfa_datapath.sv */
// datapath: config registers, size table, taken flags, scan compare and result register
`timescale 1ns / 1ps

module fpfa_datapath
    import fpfa_pkg::*;
#(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  fpfa_cmd_t             cmd,
    output fpfa_status_t          status,
    input  logic [PIDX_W-1:0]     partition_index,
    input  logic [SIZE_IN_W-1:0]  size_value,
    input  logic                  m_tready,
    output logic                  out_valid,
    output logic                  granted,
    output logic [CHOSEN_W-1:0]   chosen_partition,
    output logic [REQNUM_W-1:0]   request_number
);

    localparam int IDX_W = $clog2(PARTITIONS);
    localparam int CNT_W = $clog2(PARTITIONS + 1);

    // configuration
    logic [POLICY_W-1:0]   policy_reg, policy_next;
    logic [PCOUNT_W-1:0]   pcount_reg, pcount_next;

    // table state
    logic [PARTITIONS-1:0] taken_reg, taken_next;
    logic [PARTITIONS-1:0] size_vld_reg, size_vld_next;
    logic [REQNUM_W-1:0]   req_cnt_reg, req_cnt_next;

    // scan state
    logic [CNT_W-1:0]      addr_reg, addr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [SIZE_BITS-1:0]  req_size_reg, req_size_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [SIZE_BITS-1:0]  best_reg, best_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_granted_reg, out_granted_next;
    logic [CHOSEN_W-1:0]   out_chosen_reg, out_chosen_next;
    logic [REQNUM_W-1:0]   out_reqnum_reg, out_reqnum_next;

    // ram and compare
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [SIZE_BITS-1:0]  ram_wdata;
    logic [SIZE_BITS-1:0]  ram_rdata;
    logic [SIZE_BITS-1:0]  entry_size;
    logic                  entry_fits;
    logic                  entry_better;
    logic                  load_in_table;
    logic [CNT_W-1:0]      active_count;

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (PARTITIONS)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign load_in_table = 32'(partition_index) < PARTITIONS;
    assign ram_we        = cmd.load && load_in_table;
    assign ram_waddr     = IDX_W'(partition_index);
    assign ram_wdata     = SIZE_BITS'(size_value);

    // partition count clipped to the table depth
    always_comb
    begin
        if (32'(pcount_reg) > PARTITIONS)
        begin
            active_count = CNT_W'(PARTITIONS);
        end
        else
        begin
            active_count = CNT_W'(pcount_reg);
        end
    end

    // an entry never loaded reads as size zero
    assign entry_size = size_vld_reg[cmp_idx_reg] ? ram_rdata : '0;
    assign entry_fits = !taken_reg[cmp_idx_reg] && (entry_size >= req_size_reg);
    assign entry_better = !found_reg
                       || ((policy_reg == FIT_BEST)  && (entry_size < best_reg))
                       || ((policy_reg == FIT_WORST) && (entry_size > best_reg));

    assign status.more        = addr_reg < count_reg;
    assign status.cmp_pending = cmp_vld_reg;
    assign status.out_free    = !out_valid_reg || m_tready;

    always_comb
    begin
        policy_next      = policy_reg;
        pcount_next      = pcount_reg;
        taken_next       = taken_reg;
        size_vld_next    = size_vld_reg;
        req_cnt_next     = req_cnt_reg;
        addr_next        = addr_reg;
        count_next       = count_reg;
        cmp_vld_next     = cmd.issue;
        cmp_idx_next     = addr_reg[IDX_W-1:0];
        req_size_next    = req_size_reg;
        found_next       = found_reg;
        pick_next        = pick_reg;
        best_next        = best_reg;
        out_valid_next   = out_valid_reg;
        out_granted_next = out_granted_reg;
        out_chosen_next  = out_chosen_reg;
        out_reqnum_next  = out_reqnum_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIT_POLICY: policy_next = cfg_data[POLICY_W-1:0];
                REG_PART_COUNT: pcount_next = cfg_data[PCOUNT_W-1:0];
                default:        policy_next = policy_reg;
            endcase
        end

        if (cmd.load)
        begin
            if (load_in_table)
            begin
                taken_next[ram_waddr]    = 1'b0;
                size_vld_next[ram_waddr] = 1'b1;
            end
            req_cnt_next = '0;
        end

        if (cmd.start)
        begin
            req_cnt_next  = req_cnt_reg + 1'b1;
            req_size_next = SIZE_BITS'(size_value);
            count_next    = active_count;
            addr_next     = '0;
            found_next    = 1'b0;
            pick_next     = '0;
            best_next     = '0;
        end

        if (cmd.issue)
        begin
            addr_next = addr_reg + 1'b1;
        end

        if (cmp_vld_reg && entry_fits && entry_better)
        begin
            found_next = 1'b1;
            pick_next  = cmp_idx_reg;
            best_next  = entry_size;
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.finish)
        begin
            if (found_reg)
            begin
                taken_next[pick_reg] = 1'b1;
            end
            out_valid_next   = 1'b1;
            out_granted_next = found_reg;
            out_chosen_next  = found_reg ? CHOSEN_W'(pick_reg) : '0;
            out_reqnum_next  = req_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POLICY_RESET;
            pcount_reg    <= PCOUNT_RESET;
            taken_reg     <= '0;
            size_vld_reg  <= '0;
            req_cnt_reg   <= '0;
            addr_reg      <= '0;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            policy_reg    <= policy_next;
            pcount_reg    <= pcount_next;
            taken_reg     <= taken_next;
            size_vld_reg  <= size_vld_next;
            req_cnt_reg   <= req_cnt_next;
            addr_reg      <= addr_next;
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg     <= cmp_idx_next;
        req_size_reg    <= req_size_next;
        pick_reg        <= pick_next;
        best_reg        <= best_next;
        out_granted_reg <= out_granted_next;
        out_chosen_reg  <= out_chosen_next;
        out_reqnum_reg  <= out_reqnum_next;
    end

    assign out_valid        = out_valid_reg;
    assign granted          = out_granted_reg;
    assign chosen_partition = out_chosen_reg;
    assign request_number   = out_reqnum_reg;

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("compare stage holds an entry beyond the active count");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && !cmd.start) |-> (CNT_W'(pick_reg) < count_reg))
        else $error("picked partition beyond the active count");

    a_pick_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && found_reg) |=> taken_reg[$past(pick_reg)])
        else $error("granted partition not marked taken");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");

    a_denied_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_granted_reg) |-> (out_chosen_reg == '0))
        else $error("denied request carries a nonzero partition");

endmodule

/* rtl/fixed_partition_fit_allocator_unit.sv */
// top level: fixed partition allocator with first, best and worst fit policies
`timescale 1ns / 1ps

//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tuser kind, tdata partition_index, size_value
//  m_*       out        m_tvalid/m_tready   tuser granted, tdata chosen_partition, request_number
//  cfg_*     in         cfg_we              cfg_index register, cfg_data value
//
//  a load is taken while idle; with the result register free a request steps through
//  accept, one ram read per active entry, compare drain, scan exit and commit
//  reset restores the config reset values and clears taken flags, table valid bits and the
//  request counter; never-loaded entries of the uncleared size table read as zero
//  a stalled m_tready holds the scan in its commit step; a new request is
//  accepted while the previous result still waits in the result register

module fixed_partition_fit_allocator_unit
    import fpfa_pkg::*;
#(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // request stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [3:0] partition_index, [19:4] size_value
    input  logic [0:0]            s_tuser,   // [0] kind

    // result stream out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [3:0] chosen_partition, [11:4] request_number
    output logic [0:0]            m_tuser,   // [0] granted

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fpfa_cmd_t             cmd;
    fpfa_status_t          status;
    logic                  res_granted;
    logic [CHOSEN_W-1:0]   res_chosen;
    logic [REQNUM_W-1:0]   res_reqnum;

    // sequencing of load, scan and commit
    fpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser[KIND_W-1:0]),
        .status   (status),
        .cmd      (cmd)
    );

    // table, scan compare and result register
    fpfa_datapath #(
        .PARTITIONS (PARTITIONS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .partition_index  (s_tdata[PIDX_W-1:0]),
        .size_value       (s_tdata[PIDX_W+SIZE_IN_W-1:PIDX_W]),
        .m_tready         (m_tready),
        .out_valid        (m_tvalid),
        .granted          (res_granted),
        .chosen_partition (res_chosen),
        .request_number   (res_reqnum)
    );

    // pack result fields, pad to whole bytes
    assign m_tdata = {4'b0000, res_reqnum, res_chosen};
    assign m_tuser = res_granted;

endmodule

/* verif/fixed_partition_fit_allocator_unit_test.sv */
// testbench: fixed partition fit allocator checked against a cycle-free predictor
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_unit_test
    import fpfa_pkg::*;
;

    localparam int TABLE_DEPTH    = 16;    // partitions in the default build
    localparam int SETTLE_CYCLES  = 32;    // covers the longest scan, plus margin
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
    localparam int ITEM_TARGET    = 760;   // stop point for the random phases
    localparam int WRAP_REQUESTS  = 290;   // enough to roll the 8-bit request number

    // one result as seen on the master side
    typedef struct packed {
        logic                granted;
        logic [CHOSEN_W-1:0] chosen;
        logic [REQNUM_W-1:0] number;
    } grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;   // [3:0] partition_index, [19:4] size_value
    logic [0:0]            s_tuser = '0;   // [0] kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [15:0]           m_tdata;        // [3:0] chosen_partition, [11:4] request_number
    logic [0:0]            m_tuser;        // [0] granted
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state, kept in step with every accepted request
    logic [SIZE_IN_W-1:0] part_size [TABLE_DEPTH];
    logic                 part_taken [TABLE_DEPTH];
    logic [REQNUM_W-1:0]  req_count;
    logic [POLICY_W-1:0]  policy_now;
    logic [PCOUNT_W-1:0]  count_now;

    grant_t expected_grants[$];
    int     failures = 0;
    int     items_sent = 0;
    int     quiet_cycles = 0;

    // idling controls
    bit     sender_gaps_on = 1'b0;
    bit     stall_on = 1'b0;
    int     burst_left = 0;
    int     ready_left = 0;
    logic   ready_phase = 1'b1;

    fixed_partition_fit_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // search the partitions in use and claim one, returns the result the block owes
    function automatic grant_t allocate_partition(input logic [SIZE_IN_W-1:0] want_size);
        grant_t r;
        int     active;
        logic   found;
        int     pick;
        active = (count_now > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_now);
        found  = 1'b0;
        pick   = 0;
        req_count = req_count + 1'b1;
        for (int j = 0; j < active; j++) begin
            if (!part_taken[j] && part_size[j] >= want_size) begin
                if (!found) begin
                    found = 1'b1;
                    pick  = j;
                end
                // first fit and the unused code keep the lowest index
                else if (policy_now == FIT_BEST && part_size[j] < part_size[pick])
                    pick = j;
                else if (policy_now == FIT_WORST && part_size[j] > part_size[pick])
                    pick = j;
            end
        end
        if (found)
            part_taken[pick] = 1'b1;
        r.granted = found;
        r.chosen  = found ? CHOSEN_W'(pick) : '0;
        r.number  = req_count;
        return r;
    endfunction

    // size for an allocation request, mostly near something already loaded
    function automatic logic [SIZE_IN_W-1:0] pick_request_size();
        int   sel;
        int   j;
        sel = $urandom_range(0, 9);
        j   = $urandom_range(0, TABLE_DEPTH - 1);
        case (sel)
            0: return '0;
            1: return '1;
            2: return SIZE_IN_W'($urandom);
            3: return part_size[j] + 1'b1;
            default: return (part_size[j] > 3) ? part_size[j] - SIZE_IN_W'($urandom_range(0, 3))
                                               : part_size[j];
        endcase
    endfunction

    task automatic report_failure(input string what, input grant_t want, input grant_t got);
        failures++;
        if (failures <= 10)
            $display("%s at %0t: expected granted=%0d part=%0d num=%0d, got granted=%0d part=%0d num=%0d",
                     what, $time, want.granted, want.chosen, want.number,
                     got.granted, got.chosen, got.number);
    endtask

    // drive one request on the slave side and predict its effect once accepted
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [PIDX_W-1:0] idx,
                             input logic [SIZE_IN_W-1:0] sz);
        if (sender_gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, sz, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (kind == KIND_LOAD) begin
            // a load frees the slot and restarts numbering, no result
            part_size[idx]  = sz;
            part_taken[idx] = 1'b0;
            req_count       = '0;
        end
        else
            expected_grants.push_back(allocate_partition(sz));
    endtask

    // stop sending, let every owed result come back, then let a trailing load settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register writes happen only with the block idle
    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FIT_POLICY)
            policy_now = value[POLICY_W-1:0];
        else
            count_now = value[PCOUNT_W-1:0];
    endtask

    // hand-picked cases: reset table, every policy, ties, count edges, loads past count
    task automatic test_directed_cases();
        sender_gaps_on = 1'b0;
        stall_on       = 1'b0;
        // fresh table is all zero sized: a zero-size request fits, size one does not
        send_item(KIND_REQUEST, 4'd0, 16'd0);
        send_item(KIND_REQUEST, 4'hF, 16'd1);
        send_item(KIND_LOAD, 4'd0, 16'd100);
        send_item(KIND_LOAD, 4'd1, 16'd50);
        send_item(KIND_LOAD, 4'd2, 16'd300);
        send_item(KIND_LOAD, 4'd3, 16'd50);
        send_item(KIND_LOAD, 4'hF, 16'hFFFF);
        send_item(KIND_REQUEST, 4'd9, 16'd40);
        // best fit with two equal sizes, lower index should win
        apply_setting(REG_FIT_POLICY, CFG_DATA_W'(FIT_BEST));
        send_item(KIND_LOAD, 4'd0, 16'd100);
        send_item(KIND_REQUEST, 4'd0, 16'd40);
        apply_setting(REG_FIT_POLICY, CFG_DATA_W'(FIT_WORST));
        send_item(KIND_REQUEST, 4'd0, 16'd40);
        send_item(KIND_REQUEST, 4'd0, 16'hFFFF);
        // unused policy code, high data bits set, should act as first fit
        apply_setting(REG_FIT_POLICY, 5'b11111);
        send_item(KIND_REQUEST, 4'd0, 16'd1);
        // nothing in use, nothing granted
        apply_setting(REG_PART_COUNT, 5'd0);
        send_item(KIND_REQUEST, 4'd0, 16'd0);
        // count past the table clamps to the full table
        apply_setting(REG_PART_COUNT, 5'd31);
        apply_setting(REG_FIT_POLICY, CFG_DATA_W'(FIT_WORST));
        send_item(KIND_LOAD, 4'hF, 16'hFFFF);
        send_item(KIND_REQUEST, 4'd0, 16'd0);
        // single partition in use, a load beyond it is stored but never searched
        apply_setting(REG_PART_COUNT, 5'd1);
        apply_setting(REG_FIT_POLICY, CFG_DATA_W'(FIT_BEST));
        send_item(KIND_LOAD, 4'd5, 16'd1000);
        send_item(KIND_REQUEST, 4'd0, 16'd500);
        send_item(KIND_LOAD, 4'd0, 16'd10);
        send_item(KIND_REQUEST, 4'd0, 16'd0);
        apply_setting(REG_PART_COUNT, 5'd16);
        apply_setting(REG_FIT_POLICY, CFG_DATA_W'(FIT_FIRST));
        send_item(KIND_REQUEST, 4'd0, 16'd1000);
        wait_idle();
    endtask

    // long run of allocation requests with no load so the number rolls over
    task automatic test_request_number_wrap();
        sender_gaps_on = 1'b1;
        stall_on       = 1'b1;
        apply_setting(REG_PART_COUNT, 5'd16);
        for (int j = 0; j < TABLE_DEPTH; j++)
            send_item(KIND_LOAD, PIDX_W'(j), SIZE_IN_W'($urandom_range(0, 2000)));
        repeat (WRAP_REQUESTS)
            send_item(KIND_REQUEST, PIDX_W'($urandom), SIZE_IN_W'($urandom_range(0, 2500)));
        wait_idle();
    endtask

    // phases of: new settings, a table fill, then allocation requests with stray loads
    task automatic test_random_phases();
        int                    phase;
        int                    n_alloc;
        logic [CFG_DATA_W-1:0] count_val;
        logic [CFG_DATA_W-1:0] policy_val;
        bit                    narrow;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            // policy cycles through all four codes, junk in the upper data bits
            policy_val = {3'($urandom_range(0, 7)), 2'(phase % 4)};
            case ($urandom_range(0, 7))
                0: count_val = 5'd0;
                1: count_val = 5'd1;
                2: count_val = 5'd16;
                3: count_val = 5'd31;
                4: count_val = 5'($urandom_range(17, 30));
                default: count_val = 5'($urandom_range(2, 16));
            endcase
            apply_setting(REG_FIT_POLICY, policy_val);
            apply_setting(REG_PART_COUNT, count_val);
            sender_gaps_on = ($urandom_range(0, 2) != 0);
            stall_on       = ($urandom_range(0, 2) != 0);
            narrow         = $urandom_range(0, 1);
            // fill the slots in use, plus a few beyond the count
            for (int j = 0; j < TABLE_DEPTH; j++)
                if (j < count_val || $urandom_range(0, 5) == 0)
                    send_item(KIND_LOAD, PIDX_W'(j),
                              narrow ? SIZE_IN_W'($urandom_range(0, 63)) : SIZE_IN_W'($urandom));
            n_alloc = $urandom_range(8, 30);
            repeat (n_alloc) begin
                if ($urandom_range(0, 11) == 0)
                    send_item(KIND_LOAD, PIDX_W'($urandom), SIZE_IN_W'($urandom));
                else
                    send_item(KIND_REQUEST, PIDX_W'($urandom), pick_request_size());
            end
            phase++;
        end
        wait_idle();
    endtask

    // result checker, every accepted result against the oldest prediction
    always @(posedge clk) begin
        grant_t got;
        grant_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.granted = m_tuser[0];
            got.chosen  = m_tdata[3:0];
            got.number  = m_tdata[11:4];
            if (expected_grants.size() == 0)
                report_failure("unexpected result", '0, got);
            else begin
                want = expected_grants.pop_front();
                if (got.granted !== want.granted || got.chosen !== want.chosen ||
                    got.number !== want.number)
                    report_failure("result mismatch", want, got);
            end
        end
    end

    // receiver: alternating ready and stall runs, sometimes a long stall
    always @(posedge clk) begin
        if (!stall_on)
            m_tready <= 1'b1;
        else if (ready_left == 0) begin
            ready_phase = !ready_phase;
            m_tready <= ready_phase;
            if (ready_phase)
                ready_left = $urandom_range(1, 10);
            else if ($urandom_range(0, 7) == 0)
                ready_left = $urandom_range(20, 40);
            else
                ready_left = $urandom_range(1, 5);
        end
        else
            ready_left--;
    end

    // watchdog on handshake activity
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            part_size[j]  = '0;
            part_taken[j] = 1'b0;
        end
        req_count  = '0;
        policy_now = POLICY_RESET;
        count_now  = PCOUNT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_request_number_wrap();
        test_random_phases();
        wait_idle();
        if (failures == 0 && expected_grants.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* fixed_partition_fit_allocator_unit.f */
rtl/fpfa_pkg.sv
rtl/fpfa_ram.sv
rtl/fpfa_ctrl.sv
rtl/fpfa_datapath.sv
rtl/fixed_partition_fit_allocator_unit.sv
verif/fixed_partition_fit_allocator_unit_test.sv
